// ===== hw/rtl/command_line_tokenize_and_check_macros.svh =====
// Assertion macros for the command line tokenizer.
`ifndef COMMAND_LINE_TOKENIZE_AND_CHECK_MACROS_SVH
`define COMMAND_LINE_TOKENIZE_AND_CHECK_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CLTC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cltc assertion failed");
`define CLTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cltc assertion failed");
`else
`define CLTC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define CLTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/cltc_pkg.sv =====
// Types, constants and helpers shared by the command line tokenizer.
`timescale 1ns / 1ps
package cltc_pkg;

    typedef enum logic [1:0] {
        PH_BODY,
        PH_HEX,
        PH_IGNORE,
        PH_OVER
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_SUM,
        KIND_XOR,
        KIND_OVER
    } kind_t;

    localparam logic [7:0] CHAR_SPACE       = 8'h20;
    localparam logic [7:0] CHAR_STAR        = 8'h2A;
    localparam logic [7:0] CHAR_CARET       = 8'h5E;
    localparam logic [7:0] START_CHAR_RESET = 8'd36;
    localparam logic [1:0] HEX_DIGITS_FULL  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] echo_byte;
        logic [3:0] token_number;
        logic       token_start;
        logic       is_separator;
        logic       is_payload;
        logic       line_done;
        logic       line_ok;
        logic [3:0] token_count;
        kind_t      check_kind;
    } result_t;

    // bit 4 set when c is a hex digit, bits 3:0 its value
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/command_line_tokenize_and_check.sv =====
// Top level of the command line tokenizer and checksum checker.
`timescale 1ns / 1ps
`include "command_line_tokenize_and_check_macros.svh"
// Usage:
//  cfg_*     write start_char (seeds both checksums, resets to '$'); cfg_ready is
//            always high; write only while the block is idle.
//  s_axis_*  one line byte per item after the start character; tuser marks the
//            command letter, tlast the final byte of the line.
//  m_axis_*  one result item per input item, in order: the byte echoed with its
//            token index and class flags; on tlast the verdict, token count and
//            check kind, otherwise those are zero.
//  An accepted input passes through an input register, then the parse step into
//  the result register. One item per cycle sustained while m_axis_tready stays
//  high; the parse state update is a combinational 8-bit add, xor and compare.
//  While the receiver stalls, the result register holds and the input register
//  still takes one more item, then s_axis_tready drops until the result moves.
//  Reset empties both registers, closes any open line and restores start_char.
module command_line_tokenize_and_check #(
    parameter int MAX_TOKENS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] first_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] echo_byte, [11:8] token_number, [12] line_ok, [16:13] token_count,
    // [18:17] check_kind, [23:19] zero
    output logic [23:0] m_axis_tdata,
    // [0] token_start, [1] is_separator, [2] is_payload
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast    // line_done
);

    logic [7:0]         start_char_reg;
    logic               in_valid_reg;
    cltc_pkg::in_item_t in_item_reg;
    logic               out_valid_reg;
    cltc_pkg::result_t  out_res_reg;
    cltc_pkg::result_t  res;
    logic               move;
    logic               s_accept;

    assign cfg_ready     = 1'b1;
    assign move          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || move;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_char_reg <= cltc_pkg::START_CHAR_RESET;
        end
        else if (cfg_valid)
        begin
            start_char_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.data_byte  <= s_axis_tdata;
            in_item_reg.first_byte <= s_axis_tuser[0];
            in_item_reg.last_byte  <= s_axis_tlast;
        end
    end

    cltc_parser #(
        .MAX_TOKENS (MAX_TOKENS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_char (start_char_reg),
        .step       (move),
        .item       (in_item_reg),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_res_reg.line_done;
    assign m_axis_tuser  = {out_res_reg.is_payload, out_res_reg.is_separator,
                            out_res_reg.token_start};
    assign m_axis_tdata  = {5'd0, out_res_reg.check_kind, out_res_reg.token_count,
                            out_res_reg.line_ok, out_res_reg.token_number,
                            out_res_reg.echo_byte};

    `CLTC_ASSERT_SAME(a_verdict_only_at_end, clk, rst_n,
        m_axis_tvalid && !m_axis_tlast, m_axis_tdata[18:12] == 7'd0)
    `CLTC_ASSERT_SAME(a_ok_not_overflow, clk, rst_n,
        m_axis_tvalid && m_axis_tdata[12], m_axis_tdata[18:17] != cltc_pkg::KIND_OVER)
    `CLTC_ASSERT_SAME(a_class_exclusive, clk, rst_n,
        m_axis_tvalid, !(m_axis_tuser[1] && m_axis_tuser[2]))
    `CLTC_ASSERT_NEXT(a_step_gives_result, clk, rst_n, move, m_axis_tvalid)

endmodule

// ===== hw/rtl/cltc_parser.sv =====
// Per-line parse state and the combinational step for one byte.
`timescale 1ns / 1ps
module cltc_parser #(
    parameter int MAX_TOKENS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         start_char,
    input  logic               step,
    input  cltc_pkg::in_item_t item,
    output cltc_pkg::result_t  res
);

    localparam logic [3:0] TOKEN_LIMIT = 4'(MAX_TOKENS);

    cltc_pkg::phase_t phase_reg, phase_next;
    cltc_pkg::kind_t  kind_reg, kind_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] xor_reg, xor_next;
    logic [3:0] tokens_reg, tokens_next;
    logic [7:0] hex_value_reg, hex_value_next;
    logic [1:0] hex_digits_reg, hex_digits_next;
    logic       hex_bad_reg, hex_bad_next;

    logic [4:0] nib;
    logic [7:0] want;
    logic       good;
    logic [7:0] b;

    assign b   = item.data_byte;
    assign nib = cltc_pkg::hex_nibble(b);

    always_comb
    begin
        phase_next      = phase_reg;
        kind_next       = kind_reg;
        sum_next        = sum_reg;
        xor_next        = xor_reg;
        tokens_next     = tokens_reg;
        hex_value_next  = hex_value_reg;
        hex_digits_next = hex_digits_reg;
        hex_bad_next    = hex_bad_reg;
        want            = 8'd0;
        good            = 1'b0;
        res             = '0;
        res.echo_byte   = b;
        res.line_done   = item.last_byte;

        if (item.first_byte || tokens_reg == 4'd0)
        begin
            // command letter opens a line, even when no first flag came
            phase_next       = cltc_pkg::PH_BODY;
            sum_next         = start_char + b;
            xor_next         = start_char ^ b;
            tokens_next      = 4'd1;
            kind_next        = cltc_pkg::KIND_NONE;
            hex_value_next   = 8'd0;
            hex_digits_next  = 2'd0;
            hex_bad_next     = 1'b0;
            res.token_start  = 1'b1;
            res.is_payload   = 1'b1;
        end
        else
        begin
            res.token_number = tokens_reg - 4'd1;
            unique case (phase_reg)
                cltc_pkg::PH_BODY:
                begin
                    priority if (b == cltc_pkg::CHAR_SPACE)
                    begin
                        res.is_separator = 1'b1;
                        if (tokens_reg >= TOKEN_LIMIT)
                        begin
                            kind_next  = cltc_pkg::KIND_OVER;
                            phase_next = cltc_pkg::PH_OVER;
                        end
                        else
                        begin
                            sum_next         = sum_reg + b;
                            xor_next         = xor_reg ^ b;
                            res.token_number = tokens_reg;
                            tokens_next      = tokens_reg + 4'd1;
                            res.token_start  = 1'b1;
                        end
                    end
                    else if (b == cltc_pkg::CHAR_STAR || b == cltc_pkg::CHAR_CARET)
                    begin
                        res.is_separator = 1'b1;
                        kind_next        = (b == cltc_pkg::CHAR_STAR) ?
                                           cltc_pkg::KIND_SUM : cltc_pkg::KIND_XOR;
                        phase_next       = cltc_pkg::PH_HEX;
                        hex_value_next   = 8'd0;
                        hex_digits_next  = 2'd0;
                        hex_bad_next     = 1'b0;
                    end
                    else
                    begin
                        sum_next       = sum_reg + b;
                        xor_next       = xor_reg ^ b;
                        res.is_payload = 1'b1;
                    end
                end
                cltc_pkg::PH_HEX:
                begin
                    if (!nib[4])
                    begin
                        hex_bad_next = 1'b1;
                    end
                    else
                    begin
                        hex_value_next = {hex_value_reg[3:0], nib[3:0]};
                    end
                    hex_digits_next = hex_digits_reg + 2'd1;
                    if (hex_digits_next >= cltc_pkg::HEX_DIGITS_FULL)
                    begin
                        phase_next = cltc_pkg::PH_IGNORE;
                    end
                end
                cltc_pkg::PH_IGNORE, cltc_pkg::PH_OVER:
                begin
                end
            endcase
        end

        if (item.last_byte)
        begin
            unique case (kind_next)
                cltc_pkg::KIND_NONE: good = (phase_next != cltc_pkg::PH_OVER);
                cltc_pkg::KIND_OVER: good = 1'b0;
                cltc_pkg::KIND_SUM, cltc_pkg::KIND_XOR:
                begin
                    want = (kind_next == cltc_pkg::KIND_SUM) ? sum_next : xor_next;
                    good = (hex_digits_next >= cltc_pkg::HEX_DIGITS_FULL) &&
                           !hex_bad_next && (hex_value_next == want);
                end
            endcase
            res.line_ok     = good;
            res.token_count = good ? tokens_next : 4'd0;
            res.check_kind  = kind_next;
            tokens_next     = 4'd0;
            phase_next      = cltc_pkg::PH_BODY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= cltc_pkg::PH_BODY;
            kind_reg       <= cltc_pkg::KIND_NONE;
            sum_reg        <= 8'd0;
            xor_reg        <= 8'd0;
            tokens_reg     <= 4'd0;
            hex_value_reg  <= 8'd0;
            hex_digits_reg <= 2'd0;
            hex_bad_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            kind_reg       <= kind_next;
            sum_reg        <= sum_next;
            xor_reg        <= xor_next;
            tokens_reg     <= tokens_next;
            hex_value_reg  <= hex_value_next;
            hex_digits_reg <= hex_digits_next;
            hex_bad_reg    <= hex_bad_next;
        end
    end

endmodule
